[design/vae_pkg.sv]
// Shared types, constants and the arctangent table for the azimuth/elevation block.
package vae_pkg;

  localparam int COORD_W     = 32;
  localparam int DELTA_SHIFT = 57 - COORD_W;
  localparam int DATA_W      = 61;
  localparam int ANG_W       = 27;
  localparam int ANG_Q       = 16;
  localparam int GAIN_Q      = 16;
  localparam int PITCH_W     = 15;
  localparam int YAW_W       = 16;

  localparam logic [GAIN_Q-1:0] INV_GAIN = GAIN_Q'(39797);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DATA_W-1:0]  data_t;
  typedef logic signed [ANG_W-1:0]   ang_t;

  typedef struct packed {
    coord_t eye_x;
    coord_t eye_y;
    coord_t eye_z;
    coord_t target_x;
    coord_t target_y;
    coord_t target_z;
  } vae_in_t;

  typedef struct packed {
    logic signed [PITCH_W-1:0] neg_pitch;
    logic signed [YAW_W-1:0]   yaw_angle;
  } vae_out_t;

  typedef struct packed {
    data_t x;
    data_t y;
    ang_t  z;
  } cordic_vec_t;

  // Rounded atan(2^-i) in degrees with 16 fraction bits.
  function automatic ang_t atan_q16(input int unsigned idx);
    ang_t val;
    case (idx)
      0:       val = ANG_W'(2949120);
      1:       val = ANG_W'(1740967);
      2:       val = ANG_W'(919879);
      3:       val = ANG_W'(466945);
      4:       val = ANG_W'(234379);
      5:       val = ANG_W'(117304);
      6:       val = ANG_W'(58666);
      7:       val = ANG_W'(29335);
      8:       val = ANG_W'(14668);
      9:       val = ANG_W'(7334);
      10:      val = ANG_W'(3667);
      11:      val = ANG_W'(1833);
      12:      val = ANG_W'(917);
      13:      val = ANG_W'(458);
      14:      val = ANG_W'(229);
      15:      val = ANG_W'(115);
      16:      val = ANG_W'(57);
      17:      val = ANG_W'(29);
      18:      val = ANG_W'(14);
      19:      val = ANG_W'(7);
      20:      val = ANG_W'(4);
      21:      val = ANG_W'(2);
      22:      val = ANG_W'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

[design/vector_to_azimuth_elevation_top.sv]
// Top level: sight-line yaw and negated pitch from eye and target points by pipelined CORDIC.
// Registers in order: stage 0, stage 1, yaw pass, gain stages, pitch pass, finish stages.
// Throughput: one word per cycle; busy stays low, since every stage is a plain register
// and the receiver cannot stall the result port.
// Each CORDIC micro-rotation has its own register stage, and these two passes set the depth.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
module vector_to_azimuth_elevation_top import vae_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  vae_in_t  in_i,
  output logic     strobe_o,
  output vae_out_t result_o
);

  localparam int LATENCY = 2 * CORDIC_STEPS + 6;

  // Angle conversion from Q16 degrees to output units, round half up.
  localparam int   SH         = ANG_Q - ANGLE_FRAC_BITS;
  localparam ang_t ROUND_HALF = ANG_W'(1 << (SH - 1));
  localparam ang_t ANG_90_Q   = ANG_W'(90 * (1 << ANG_Q));
  localparam ang_t ANG_180_Q  = ANG_W'(180 * (1 << ANG_Q));
  localparam ang_t OUT_FULL   = ANG_W'(360 * (1 << ANGLE_FRAC_BITS));
  localparam ang_t OUT_HALF   = ANG_W'(180 * (1 << ANGLE_FRAC_BITS));
  localparam ang_t OUT_QUART  = ANG_W'(90 * (1 << ANGLE_FRAC_BITS));

  localparam int HI_W   = DATA_W - 1 - GAIN_Q;
  localparam int HI_P_W = HI_W + GAIN_Q;
  localparam int LO_P_W = 2 * GAIN_Q;

  // Side data carried through the yaw pass and the pitch pass.
  typedef struct packed {
    data_t dy;
    logic  hz_zero;
  } yaw_side_t;

  typedef struct packed {
    ang_t yaw_r;
    logic pz;
  } pitch_side_t;

  localparam int YAW_SIDE_W   = $bits(yaw_side_t);
  localparam int PITCH_SIDE_W = $bits(pitch_side_t);

  // The pipeline never stalls, so a word is taken whenever start is high.
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Stage 0: delta vector, aligned so that every coordinate width lands on the
  // same high bits of the CORDIC datapath.
  // ---------------------------------------------------------------------------
  logic  s0_valid_q;
  data_t s0_dx_d, s0_dy_d, s0_dz_d;
  data_t s0_dx_q, s0_dy_q, s0_dz_q;

  always_comb begin
    s0_dx_d = (data_t'(in_i.target_x) - data_t'(in_i.eye_x)) <<< DELTA_SHIFT;
    s0_dy_d = (data_t'(in_i.target_y) - data_t'(in_i.eye_y)) <<< DELTA_SHIFT;
    s0_dz_d = (data_t'(in_i.target_z) - data_t'(in_i.eye_z)) <<< DELTA_SHIFT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_dx_q <= s0_dx_d;
    s0_dy_q <= s0_dy_d;
    s0_dz_q <= s0_dz_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: a vector in the left half plane is turned by 180 degrees first, so
  // that the vectoring pass only ever sees x >= 0. The start angle is then +180
  // for dz >= 0 and -180 otherwise. A zero horizontal delta is flagged here; its
  // yaw angle and horizontal magnitude are forced to zero after the pass.
  // ---------------------------------------------------------------------------
  logic        s1_valid_q;
  cordic_vec_t s1_vec_d, s1_vec_q;
  yaw_side_t   s1_side_d, s1_side_q;

  always_comb begin
    if (s0_dx_q[DATA_W-1]) begin
      s1_vec_d.x = -s0_dx_q;
      s1_vec_d.y = -s0_dz_q;
      s1_vec_d.z = s0_dz_q[DATA_W-1] ? -ANG_180_Q : ANG_180_Q;
    end else begin
      s1_vec_d.x = s0_dx_q;
      s1_vec_d.y = s0_dz_q;
      s1_vec_d.z = '0;
    end
    s1_side_d.dy      = s0_dy_q;
    s1_side_d.hz_zero = (s0_dx_q == '0) && (s0_dz_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_vec_q  <= s1_vec_d;
    s1_side_q <= s1_side_d;
  end

  // ---------------------------------------------------------------------------
  // Yaw pass: one register stage per micro-rotation on (dx, dz).
  // ---------------------------------------------------------------------------
  logic                  yaw_valid [CORDIC_STEPS+1];
  cordic_vec_t           yaw_vec   [CORDIC_STEPS+1];
  logic [YAW_SIDE_W-1:0] yaw_side  [CORDIC_STEPS+1];

  assign yaw_valid[0] = s1_valid_q;
  assign yaw_vec[0]   = s1_vec_q;
  assign yaw_side[0]  = s1_side_q;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_yaw
    vae_cordic_stage #(
      .STEP  (k),
      .SIDE_W(YAW_SIDE_W)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(yaw_valid[k]),
      .vec_i  (yaw_vec[k]),
      .side_i (yaw_side[k]),
      .valid_o(yaw_valid[k+1]),
      .vec_o  (yaw_vec[k+1]),
      .side_o (yaw_side[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Gain stage 1: the yaw pass leaves the horizontal magnitude times the CORDIC
  // gain in x. It is scaled by the inverse gain in Q16, split into a high and a
  // low partial product so that each multiplier stays narrow.
  // ---------------------------------------------------------------------------
  cordic_vec_t yaw_end;
  yaw_side_t   yaw_end_side;
  data_t       gx_pos;

  logic              m1_valid_q;
  logic [HI_P_W-1:0] m1_hi_d, m1_hi_q;
  logic [LO_P_W-1:0] m1_lo_d, m1_lo_q;
  ang_t              m1_yaw_z_q;
  yaw_side_t         m1_side_q;

  always_comb begin
    yaw_end      = yaw_vec[CORDIC_STEPS];
    yaw_end_side = yaw_side[CORDIC_STEPS];
    gx_pos       = yaw_end.x[DATA_W-1] ? data_t'(0) : yaw_end.x;
    m1_hi_d      = gx_pos[DATA_W-2:GAIN_Q] * INV_GAIN;
    m1_lo_d      = gx_pos[GAIN_Q-1:0] * INV_GAIN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
    end else begin
      m1_valid_q <= yaw_valid[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    m1_hi_q    <= m1_hi_d;
    m1_lo_q    <= m1_lo_d;
    m1_yaw_z_q <= yaw_end.z;
    m1_side_q  <= yaw_end_side;
  end

  // ---------------------------------------------------------------------------
  // Gain stage 2: sum the partial products into the horizontal magnitude and set
  // up the pitch pass on (horiz, dy). The yaw angle less 90 degrees is rounded to
  // output units here, so it rides through the pitch pass already converted. When
  // both the horizontal magnitude and dy are zero, the pitch angle is forced to zero.
  // ---------------------------------------------------------------------------
  data_t       horiz;
  ang_t        yaw_q16;

  logic        m2_valid_q;
  cordic_vec_t m2_vec_d, m2_vec_q;
  pitch_side_t m2_side_d, m2_side_q;

  always_comb begin
    if (m1_side_q.hz_zero) begin
      horiz   = '0;
      yaw_q16 = '0;
    end else begin
      horiz   = data_t'({1'b0, m1_hi_q + HI_P_W'(m1_lo_q[LO_P_W-1:GAIN_Q])});
      yaw_q16 = m1_yaw_z_q;
    end
    m2_vec_d.x      = horiz;
    m2_vec_d.y      = m1_side_q.dy;
    m2_vec_d.z      = '0;
    m2_side_d.yaw_r = (yaw_q16 - ANG_90_Q + ROUND_HALF) >>> SH;
    m2_side_d.pz    = (horiz == '0) && (m1_side_q.dy == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_valid_q <= 1'b0;
    end else begin
      m2_valid_q <= m1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m2_vec_q  <= m2_vec_d;
    m2_side_q <= m2_side_d;
  end

  // ---------------------------------------------------------------------------
  // Pitch pass: one register stage per micro-rotation on (horiz, dy).
  // ---------------------------------------------------------------------------
  logic                    pit_valid [CORDIC_STEPS+1];
  cordic_vec_t             pit_vec   [CORDIC_STEPS+1];
  logic [PITCH_SIDE_W-1:0] pit_side  [CORDIC_STEPS+1];

  assign pit_valid[0] = m2_valid_q;
  assign pit_vec[0]   = m2_vec_q;
  assign pit_side[0]  = m2_side_q;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_pitch
    vae_cordic_stage #(
      .STEP  (k),
      .SIDE_W(PITCH_SIDE_W)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(pit_valid[k]),
      .vec_i  (pit_vec[k]),
      .side_i (pit_side[k]),
      .valid_o(pit_valid[k+1]),
      .vec_o  (pit_vec[k+1]),
      .side_o (pit_side[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Finish stage 1: round the pitch angle and wrap the yaw into [-180, 180).
  // The vectoring pass always lands near the true angle, so the shifted yaw is
  // never more than one full turn out of range and a single add or subtract of
  // 360 degrees does the modulo.
  // ---------------------------------------------------------------------------
  cordic_vec_t pit_end;
  pitch_side_t pit_end_side;
  ang_t        pitch_q16, yaw_shift;

  logic        f1_valid_q;
  ang_t        f1_pitch_d, f1_pitch_q;
  ang_t        f1_yaw_d, f1_yaw_q;

  always_comb begin
    pit_end      = pit_vec[CORDIC_STEPS];
    pit_end_side = pit_side[CORDIC_STEPS];
    pitch_q16    = pit_end_side.pz ? ang_t'(0) : pit_end.z;
    f1_pitch_d   = (pitch_q16 + ROUND_HALF) >>> SH;
    yaw_shift    = pit_end_side.yaw_r + OUT_HALF;
    if (yaw_shift < 0) begin
      yaw_shift = yaw_shift + OUT_FULL;
    end else if (yaw_shift >= OUT_FULL) begin
      yaw_shift = yaw_shift - OUT_FULL;
    end
    f1_yaw_d = yaw_shift - OUT_HALF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= pit_valid[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    f1_pitch_q <= f1_pitch_d;
    f1_yaw_q   <= f1_yaw_d;
  end

  // ---------------------------------------------------------------------------
  // Finish stage 2: saturate the pitch to +/-90 degrees, negate it and cut both
  // angles to the field widths. This register drives the result port directly,
  // and strobe_o is high for the one cycle in which the word is presented.
  // ---------------------------------------------------------------------------
  ang_t     pitch_sat, pitch_neg;
  logic     strobe_q;
  vae_out_t result_d, result_q;

  always_comb begin
    pitch_sat = f1_pitch_q;
    if (pitch_sat > OUT_QUART) begin
      pitch_sat = OUT_QUART;
    end else if (pitch_sat < -OUT_QUART) begin
      pitch_sat = -OUT_QUART;
    end
    pitch_neg          = -pitch_sat;
    result_d.neg_pitch = pitch_neg[PITCH_W-1:0];
    result_d.yaw_angle = f1_yaw_q[YAW_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign strobe_o = strobe_q;
  assign result_o = result_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Every accepted word comes out after exactly the pipeline latency.
  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY strobe_o)
    else $error("accepted word did not produce a result after the pipeline latency");

  // No result appears without a word accepted one latency earlier.
  a_latency_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(accept, LATENCY))
    else $error("result strobe without a matching accepted word");

  // At the default angle scale the wrapped yaw stays inside [-180, 180).
  a_yaw_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (ANGLE_FRAC_BITS > 7) ||
                 ((result_o.yaw_angle >= -OUT_HALF) && (result_o.yaw_angle < OUT_HALF)))
    else $error("yaw angle outside the wrapped range");

  // At the default angle scale the negated pitch stays inside [-90, 90].
  a_pitch_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (ANGLE_FRAC_BITS > 7) ||
                 ((result_o.neg_pitch >= -OUT_QUART) && (result_o.neg_pitch <= OUT_QUART)))
    else $error("pitch angle outside the saturation bounds");

endmodule

[design/vae_cordic_stage.sv]
// One registered vectoring CORDIC micro-rotation with side data carried alongside.
module vae_cordic_stage import vae_pkg::*; #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  cordic_vec_t       vec_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output cordic_vec_t       vec_o,
  output logic [SIDE_W-1:0] side_o
);

  data_t       x_in, y_in, xs, ys;
  ang_t        z_in;
  cordic_vec_t vec_d, vec_q;
  logic [SIDE_W-1:0] side_q;
  logic        valid_q;

  always_comb begin
    x_in = vec_i.x;
    y_in = vec_i.y;
    z_in = vec_i.z;
    xs   = x_in >>> STEP;
    ys   = y_in >>> STEP;
    // Rotate toward the x axis: the sign of y picks the direction.
    if (!y_in[DATA_W-1]) begin
      vec_d.x = x_in + ys;
      vec_d.y = y_in - xs;
      vec_d.z = z_in + atan_q16(STEP);
    end else begin
      vec_d.x = x_in - ys;
      vec_d.y = y_in + xs;
      vec_d.z = z_in - atan_q16(STEP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q  <= vec_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign side_o  = side_q;

endmodule
